@@ src/min_max_decimator_unit_defines.svh @@
// assertion helpers used by the decimator unit
// each macro expects clk and arst_n in the scope where it is used
`ifndef MIN_MAX_DECIMATOR_UNIT_DEFINES_SVH
`define MIN_MAX_DECIMATOR_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the trigger
`define MMD_ASSERT_SAME(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (prop)) \
		else $error(msg);

// consequent must hold in the cycle after the trigger
`define MMD_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

@@ src/mmd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mmd_pkg;

	localparam int CHANNELS    = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int CH_BITS     = 4;
	localparam int CNT_BITS    = 5;
	localparam int RATIO_BITS  = 16;
	localparam int PKT_BITS    = 17;
	localparam int IDX_BITS    = 2;

	// configuration register indexes
	localparam logic [IDX_BITS-1:0] REG_RATIO = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_COUNT = 2'd1;

	// write port of the extreme store
	typedef struct packed {
		logic                          en;
		logic [CH_BITS-1:0]            addr;
		logic signed [SAMPLE_BITS-1:0] hi;
		logic signed [SAMPLE_BITS-1:0] lo;
	} store_wr_t;

	// registered read data of the extreme store
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] hi;
		logic signed [SAMPLE_BITS-1:0] lo;
	} store_rd_t;

endpackage

`default_nettype wire

@@ src/mmd_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mmd_store (
	input  wire logic                         clk,
	input  wire mmd_pkg::store_wr_t           wr,
	input  wire logic [mmd_pkg::CH_BITS-1:0]  rd_addr,
	output mmd_pkg::store_rd_t                rd
);

	logic [mmd_pkg::SAMPLE_BITS-1:0] hi_mem [mmd_pkg::CHANNELS];
	logic [mmd_pkg::SAMPLE_BITS-1:0] lo_mem [mmd_pkg::CHANNELS];

	// one write port, both extremes of a channel written together
	always_ff @(posedge clk) begin
		if (wr.en) begin
			hi_mem[wr.addr] <= wr.hi;
			lo_mem[wr.addr] <= wr.lo;
		end
	end

	// registered read, returns the old entry on a same-cycle write
	always_ff @(posedge clk) begin
		rd.hi <= $signed(hi_mem[rd_addr]);
		rd.lo <= $signed(lo_mem[rd_addr]);
	end

endmodule

`default_nettype wire

@@ src/min_max_decimator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel     | handshake                    | payload
// ------------+------------------------------+------------------------------
// sample      | sample_valid / sample_stall  | sample
// result      | result_valid / result_stall  | value, chan, is_min, last
// config      | write_en                     | reg_index, write_data
//
// Inside a chunk one sample is taken per cycle; the extreme store is read at
// acceptance and written back in the next cycle, with a forward of the last write.
// At chunk end the input stalls for the final write and for the whole dump; the
// dump reads each entry (ST_RD), then loads it into the output register (ST_WT).
// Pass-through mode moves one sample per cycle while the result side takes it.
// arst_n resets config, counters, valid flags and dump sequencer; store contents stay.
// A stalled result holds the output register; in pass-through the input stalls too.

`include "min_max_decimator_unit_defines.svh"

module min_max_decimator_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  write_en,
	input  wire logic [mmd_pkg::IDX_BITS-1:0]          reg_index,
	input  wire logic [mmd_pkg::RATIO_BITS-1:0]        write_data,
	input  wire logic                                  sample_valid,
	output logic                                       sample_stall,
	input  wire logic signed [mmd_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                       result_valid,
	input  wire logic                                  result_stall,
	output logic signed [mmd_pkg::SAMPLE_BITS-1:0]     value,
	output logic [mmd_pkg::CH_BITS-1:0]                chan,
	output logic                                       is_min,
	output logic                                       last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_WT   = 2'd2;

	logic [mmd_pkg::RATIO_BITS-1:0] ratio_q;
	logic [mmd_pkg::CNT_BITS-1:0]   count_q;
	logic [mmd_pkg::CH_BITS-1:0]    ch_cnt_q;
	logic [mmd_pkg::PKT_BITS-1:0]   pkt_cnt_q;

	logic [mmd_pkg::CNT_BITS-1:0]   n_act;
	logic [mmd_pkg::CH_BITS-1:0]    ch_cur;
	logic                           eop;
	logic                           pass;
	logic                           chunk_end;
	logic                           accept;
	logic                           cfg_hit;

	logic                                 valid_s1;
	logic signed [mmd_pkg::SAMPLE_BITS-1:0] sample_s1;
	logic [mmd_pkg::CH_BITS-1:0]          ch_s1;
	logic                                 seed_s1;
	logic                                 end_s1;

	mmd_pkg::store_wr_t   wr;
	mmd_pkg::store_wr_t   fwd_q;
	mmd_pkg::store_rd_t   rd;
	logic [mmd_pkg::CH_BITS-1:0] rd_addr;
	logic signed [mmd_pkg::SAMPLE_BITS-1:0] cur_hi;
	logic signed [mmd_pkg::SAMPLE_BITS-1:0] cur_lo;

	logic [1:0]                  state_q;
	logic [mmd_pkg::CH_BITS-1:0] dchan_q;
	logic                        dmin_q;
	logic                        out_free;
	logic                        dump_load;
	logic                        dump_last;

	logic                                 res_valid_q;
	logic signed [mmd_pkg::SAMPLE_BITS-1:0] res_value_q;
	logic [mmd_pkg::CH_BITS-1:0]          res_chan_q;
	logic                                 res_min_q;
	logic                                 res_last_q;

	// active channel count, clamped to 1..CHANNELS
	always_comb begin
		if (count_q == '0) begin
			n_act = mmd_pkg::CNT_BITS'(1);
		end else if (count_q > mmd_pkg::CNT_BITS'(mmd_pkg::CHANNELS)) begin
			n_act = mmd_pkg::CNT_BITS'(mmd_pkg::CHANNELS);
		end else begin
			n_act = count_q;
		end
	end

	// packet and chunk position of the offered sample
	assign ch_cur    = ({1'b0, ch_cnt_q} >= n_act) ? '0 : ch_cnt_q;
	assign eop       = ({1'b0, ch_cur} + mmd_pkg::CNT_BITS'(1)) == n_act;
	assign pass      = ratio_q <= mmd_pkg::RATIO_BITS'(1);
	assign chunk_end = eop &&
		(({1'b0, pkt_cnt_q} + (mmd_pkg::PKT_BITS + 1)'(1)) >= {1'b0, ratio_q, 1'b0});

	// handshakes
	assign out_free     = !res_valid_q || !result_stall;
	assign sample_stall = (state_q != ST_IDLE) || (valid_s1 && end_s1) ||
		(pass && res_valid_q && result_stall);
	assign accept       = sample_valid && !sample_stall;
	assign cfg_hit      = write_en &&
		(reg_index == mmd_pkg::REG_RATIO || reg_index == mmd_pkg::REG_COUNT);

	// configuration registers and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q   <= mmd_pkg::RATIO_BITS'(1);
			count_q   <= mmd_pkg::CNT_BITS'(mmd_pkg::CHANNELS);
			ch_cnt_q  <= '0;
			pkt_cnt_q <= '0;
		end else if (cfg_hit) begin
			if (reg_index == mmd_pkg::REG_RATIO) begin
				ratio_q <= write_data;
			end else begin
				count_q <= write_data[mmd_pkg::CNT_BITS-1:0];
			end
			ch_cnt_q  <= '0;
			pkt_cnt_q <= '0;
		end else if (accept) begin
			ch_cnt_q <= eop ? '0 : ch_cur + mmd_pkg::CH_BITS'(1);
			if (pass || (eop && chunk_end)) begin
				pkt_cnt_q <= '0;
			end else if (eop) begin
				pkt_cnt_q <= pkt_cnt_q + mmd_pkg::PKT_BITS'(1);
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			end_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept && !pass;
			end_s1   <= accept && !pass && chunk_end;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			ch_s1     <= ch_cur;
			seed_s1   <= pkt_cnt_q == '0;
		end
	end

	// store read address: incoming channel, or the dump channel
	assign rd_addr = (state_q == ST_IDLE) ? ch_cur : dchan_q;

	mmd_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd      (rd)
	);

	// forward the previous write when it hit the same channel
	always_comb begin
		if (fwd_q.en && fwd_q.addr == ch_s1) begin
			cur_hi = fwd_q.hi;
			cur_lo = fwd_q.lo;
		end else begin
			cur_hi = rd.hi;
			cur_lo = rd.lo;
		end
	end

	// update of the running extremes
	always_comb begin
		wr.en   = valid_s1;
		wr.addr = ch_s1;
		wr.hi   = cur_hi;
		wr.lo   = cur_lo;
		if (seed_s1) begin
			wr.hi = sample_s1;
			wr.lo = sample_s1;
		end else if (sample_s1 > cur_hi) begin
			wr.hi = sample_s1;
		end else if (sample_s1 < cur_lo) begin
			wr.lo = sample_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= '0;
		end else begin
			fwd_q <= wr;
		end
	end

	// dump sequencer: read an entry, then hand it to the output register
	assign dump_load = (state_q == ST_WT) && out_free;
	assign dump_last = dmin_q && (({1'b0, dchan_q} + mmd_pkg::CNT_BITS'(1)) == n_act);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dchan_q <= '0;
			dmin_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (valid_s1 && end_s1) begin
						state_q <= ST_RD;
						dchan_q <= '0;
						dmin_q  <= 1'b0;
					end
				end
				ST_RD: begin
					state_q <= ST_WT;
				end
				ST_WT: begin
					if (out_free) begin
						if (dump_last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_RD;
							if (({1'b0, dchan_q} + mmd_pkg::CNT_BITS'(1)) == n_act) begin
								dchan_q <= '0;
								dmin_q  <= 1'b1;
							end else begin
								dchan_q <= dchan_q + mmd_pkg::CH_BITS'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((accept && pass) || dump_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (accept && pass) begin
			res_value_q <= sample;
			res_chan_q  <= ch_cur;
			res_min_q   <= 1'b0;
			res_last_q  <= 1'b1;
		end else if (dump_load) begin
			res_value_q <= dmin_q ? rd.lo : rd.hi;
			res_chan_q  <= dchan_q;
			res_min_q   <= dmin_q;
			res_last_q  <= dump_last;
		end
	end

	assign result_valid = res_valid_q;
	assign value        = res_value_q;
	assign chan         = res_chan_q;
	assign is_min       = res_min_q;
	assign last         = res_last_q;

	// checks
	`MMD_ASSERT_NEXT(a_dump_start, valid_s1 && end_s1, state_q == ST_RD && dchan_q == '0 && !dmin_q, "dump did not start after chunk end")
	`MMD_ASSERT_SAME(a_dump_quiet, state_q != ST_IDLE, !valid_s1, "store update during dump")
	`MMD_ASSERT_NEXT(a_pass_out, accept && pass, res_valid_q && res_last_q && !res_min_q, "pass-through transaction not presented")
	`MMD_ASSERT_NEXT(a_dump_done, dump_load && dump_last, state_q == ST_IDLE, "dump did not end after last result")

endmodule

`default_nettype wire

@@ test/min_max_decimator_unit_tb.sv @@
`timescale 1ns / 1ps

module min_max_decimator_unit_tb;

	// register indexes that decode to nothing
	localparam logic [mmd_pkg::IDX_BITS-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [mmd_pkg::IDX_BITS-1:0] REG_SPARE_HI = 2'd3;

	// settle time after the last result: full dump plus margin
	localparam int SETTLE_CYCLES = 4 * mmd_pkg::CHANNELS + 8;
	localparam int QUIET_LIMIT   = 3000;
	localparam int LONG_HOLD     = 300;
	localparam int TARGET_ITEMS  = 420;

	typedef struct {
		logic signed [mmd_pkg::SAMPLE_BITS-1:0] value;
		logic [mmd_pkg::CH_BITS-1:0]            chan;
		logic                                   is_min;
		logic                                   last;
	} extreme_t;

	logic                                   clk          = 1'b0;
	logic                                   arst_n       = 1'b0;
	logic                                   write_en     = 1'b0;
	logic [mmd_pkg::IDX_BITS-1:0]           reg_index    = '0;
	logic [mmd_pkg::RATIO_BITS-1:0]         write_data   = '0;
	logic                                   sample_valid = 1'b0;
	logic                                   sample_stall;
	logic signed [mmd_pkg::SAMPLE_BITS-1:0] sample       = '0;
	logic                                   result_valid;
	logic                                   result_stall = 1'b0;
	logic signed [mmd_pkg::SAMPLE_BITS-1:0] value;
	logic [mmd_pkg::CH_BITS-1:0]            chan;
	logic                                   is_min;
	logic                                   last;

	// shadow of the block: registers, counters and running extremes
	logic [mmd_pkg::RATIO_BITS-1:0]         ratio_reg;
	logic [mmd_pkg::CNT_BITS-1:0]           count_reg;
	logic signed [mmd_pkg::SAMPLE_BITS-1:0] peak_hi [mmd_pkg::CHANNELS];
	logic signed [mmd_pkg::SAMPLE_BITS-1:0] peak_lo [mmd_pkg::CHANNELS];
	int                                     packet_idx;
	int                                     chan_idx;

	logic signed [mmd_pkg::SAMPLE_BITS-1:0] pending_samples [$];
	extreme_t                               expected_results [$];

	int sender_idle_pct   = 0;
	int receiver_idle_pct = 0;
	int items_queued      = 0;
	int samples_taken     = 0;
	int results_checked   = 0;
	int mismatches        = 0;
	int settings_used     = 0;
	int hold_left         = 0;
	bit hold_done         = 1'b0;
	int quiet_cycles      = 0;

	min_max_decimator_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_en     (write_en),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.chan         (chan),
		.is_min       (is_min),
		.last         (last)
	);

	always #1 clk = ~clk;

	function automatic int active_channels();
		if (count_reg == 0)
			return 1;
		if (count_reg > mmd_pkg::CHANNELS)
			return mmd_pkg::CHANNELS;
		return count_reg;
	endfunction

	// any write to a real register restarts packet and chunk
	function automatic void apply_register(input logic [mmd_pkg::IDX_BITS-1:0] idx,
			input logic [mmd_pkg::RATIO_BITS-1:0] data);
		case (idx)
			mmd_pkg::REG_RATIO: ratio_reg = data;
			mmd_pkg::REG_COUNT: count_reg = data[mmd_pkg::CNT_BITS-1:0];
			default: return;
		endcase
		packet_idx = 0;
		chan_idx = 0;
	endfunction

	// update running extremes for one sample, queue any results it causes
	function automatic void predict_sample(input logic signed [mmd_pkg::SAMPLE_BITS-1:0] s);
		int n;
		int ch;
		bit end_of_packet;
		extreme_t r;
		n = active_channels();
		ch = chan_idx;
		if (ch >= n)
			ch = 0;
		end_of_packet = (ch + 1 == n);
		// pass-through
		if (ratio_reg <= 1) begin
			r.value = s;
			r.chan = mmd_pkg::CH_BITS'(ch);
			r.is_min = 1'b0;
			r.last = 1'b1;
			expected_results.push_back(r);
			chan_idx = end_of_packet ? 0 : ch + 1;
			packet_idx = 0;
			return;
		end
		// first packet seeds, later ones widen
		if (packet_idx == 0) begin
			peak_hi[ch] = s;
			peak_lo[ch] = s;
		end else if (s > peak_hi[ch]) begin
			peak_hi[ch] = s;
		end else if (s < peak_lo[ch]) begin
			peak_lo[ch] = s;
		end
		if (!end_of_packet) begin
			chan_idx = ch + 1;
			return;
		end
		chan_idx = 0;
		if (packet_idx + 1 < 2 * ratio_reg) begin
			packet_idx = packet_idx + 1;
			return;
		end
		packet_idx = 0;
		// chunk end: all maxima, then all minima
		for (int i = 0; i < n; i++) begin
			r.value = peak_hi[i];
			r.chan = mmd_pkg::CH_BITS'(i);
			r.is_min = 1'b0;
			r.last = 1'b0;
			expected_results.push_back(r);
		end
		for (int i = 0; i < n; i++) begin
			r.value = peak_lo[i];
			r.chan = mmd_pkg::CH_BITS'(i);
			r.is_min = 1'b1;
			r.last = (i + 1 == n);
			expected_results.push_back(r);
		end
	endfunction

	function automatic void check_field(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	// sample driver: registers and samples feed the predictor on acceptance
	always @(posedge clk) begin
		if (arst_n && write_en)
			apply_register(reg_index, write_data);
		if (arst_n && sample_valid && !sample_stall) begin
			predict_sample(sample);
			samples_taken++;
		end
		if (!sample_valid || !sample_stall) begin
			if (pending_samples.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				sample_valid <= 1'b1;
				sample <= pending_samples.pop_front();
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver stall
	always @(posedge clk) begin
		extreme_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got value %0d chan %0d",
					$time, value, chan);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("value", want.value, value);
				check_field("chan", want.chan, chan);
				check_field("is_min", want.is_min, is_min);
				check_field("last", want.last, last);
			end
			results_checked++;
		end
		// one long hold-off while the sender keeps offering
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			result_stall <= 1'b1;
		end else if (!hold_done && result_valid && results_checked >= 40) begin
			hold_left = LONG_HOLD;
			hold_done = 1'b1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || write_en) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [mmd_pkg::IDX_BITS-1:0] idx,
			input logic [mmd_pkg::RATIO_BITS-1:0] data);
		@(posedge clk);
		write_en <= 1'b1;
		reg_index <= idx;
		write_data <= data;
		@(posedge clk);
		write_en <= 1'b0;
	endtask

	// block is idle once all samples went in and every result came out
	task automatic wait_drained();
		while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_value(input logic signed [mmd_pkg::SAMPLE_BITS-1:0] v);
		pending_samples.push_back(v);
		items_queued++;
	endtask

	// mostly full-range codes, some extremes, some near-equal values
	function automatic logic signed [mmd_pkg::SAMPLE_BITS-1:0] pick_sample();
		logic signed [mmd_pkg::SAMPLE_BITS-1:0] v;
		case ($urandom_range(0, 9))
			0: v = 16'sh7fff;
			1: v = 16'sh8000;
			2, 3: v = 16'($urandom_range(0, 6)) - 16'd3;
			default: v = 16'($urandom());
		endcase
		return v;
	endfunction

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++)
			queue_value(pick_sample());
	endtask

	// idling follows how far the stimulus has got
	task automatic set_idling();
		if (items_queued < 140) begin
			sender_idle_pct = 15;
			receiver_idle_pct = 47;
		end else if (items_queued < 280) begin
			sender_idle_pct = 47;
			receiver_idle_pct = 15;
		end else begin
			sender_idle_pct = 0;
			receiver_idle_pct = 0;
		end
		settings_used++;
	endtask

	task automatic run_random_phase();
		int ratio;
		int count;
		int n;
		int chunk_len;
		int chunks;
		int total;
		set_idling();
		case ($urandom_range(0, 9))
			0: count = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
			default: count = $urandom_range(1, mmd_pkg::CHANNELS);
		endcase
		n = (count == 0) ? 1 : ((count > mmd_pkg::CHANNELS) ? mmd_pkg::CHANNELS : count);
		case ($urandom_range(0, 9))
			0: ratio = 0;
			1: ratio = 1;
			8, 9: ratio = $urandom_range(5, 8);
			default: ratio = $urandom_range(2, 4);
		endcase
		if (ratio > 4 && n > 8)
			ratio = 4;
		if ($urandom_range(0, 5) == 0)
			write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom()));
		if ($urandom_range(0, 1)) begin
			write_reg(mmd_pkg::REG_RATIO, 16'(ratio));
			write_reg(mmd_pkg::REG_COUNT, {11'($urandom()), 5'(count)});
		end else begin
			write_reg(mmd_pkg::REG_COUNT, {11'($urandom()), 5'(count)});
			write_reg(mmd_pkg::REG_RATIO, 16'(ratio));
		end
		// whole chunks mostly, sometimes a trailing partial one
		if (ratio <= 1) begin
			total = $urandom_range(4, 30);
		end else begin
			chunk_len = 2 * ratio * n;
			chunks = 96 / chunk_len;
			if (chunks < 1)
				chunks = 1;
			total = chunk_len * $urandom_range(1, chunks);
			if ($urandom_range(0, 5) == 0)
				total += $urandom_range(1, chunk_len - 1);
		end
		queue_random(total);
		wait_drained();
	endtask

	// stimulus
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pass-through at reset values, extreme and alternating codes
		set_idling();
		ratio_reg = 16'd1;
		count_reg = 5'd16;
		packet_idx = 0;
		chan_idx = 0;
		queue_value(16'sh7fff);
		queue_value(16'sh8000);
		queue_value(16'sh0000);
		queue_value(16'shffff);
		queue_value(16'sh5555);
		queue_value(16'shaaaa);
		wait_drained();

		// spare index leaves the channel count running
		write_reg(REG_SPARE_LO, 16'h0003);
		queue_value(16'sd12);
		queue_value(-16'sd12);
		wait_drained();

		// channel count zero acts as one
		set_idling();
		write_reg(mmd_pkg::REG_COUNT, 16'h0000);
		queue_value(16'sd1);
		queue_value(16'sd2);
		wait_drained();

		// single channel chunk: seed, new max, new min, tie with max
		set_idling();
		write_reg(mmd_pkg::REG_RATIO, 16'd2);
		write_reg(mmd_pkg::REG_COUNT, 16'd1);
		queue_value(16'sd0);
		queue_value(16'sh7fff);
		queue_value(16'sh8000);
		queue_value(16'sh7fff);
		wait_drained();

		// two channels: larger, smaller and in-between samples
		set_idling();
		write_reg(mmd_pkg::REG_COUNT, 16'd2);
		queue_value(16'sd100);
		queue_value(-16'sd100);
		queue_value(16'sd50);
		queue_value(-16'sd50);
		queue_value(16'sd200);
		queue_value(-16'sd300);
		queue_value(-16'sd20);
		queue_value(16'sd400);
		wait_drained();

		// largest ratio and all-ones count: partial chunk, no results
		set_idling();
		write_reg(mmd_pkg::REG_RATIO, 16'hffff);
		write_reg(mmd_pkg::REG_COUNT, 16'hffff);
		queue_random(40);
		wait_drained();

		// all sixteen channels, two chunks; the long hold falls in here
		set_idling();
		write_reg(mmd_pkg::REG_COUNT, 16'd16);
		write_reg(mmd_pkg::REG_RATIO, 16'd2);
		queue_random(128);
		wait_drained();

		while (items_queued < TARGET_ITEMS)
			run_random_phase();

		$display("covered %0d samples and %0d results across %0d register settings",
			samples_taken, results_checked, settings_used);
		$display("modes: pass-through, partial and full chunks, ratios 0 to 65535, 1 to 16 channels");
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
